@@ sv/fbfla_pkg.sv @@
package fbfla_pkg;

  localparam int IDX_W    = 8;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 9;

  // Count chained after reset, before capping at the pool size.
  localparam int RESET_BLOCKS = 256;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_ALLOC = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

endpackage

@@ sv/fixed_block_free_list_allocator.sv @@
// Free-list allocator for a pool of MAX_BLOCKS equal-sized blocks named by index.
// Input channel (in_*): in_tuser carries the action (allocate, free, clear) and
// in_tdata the block index to free. Each item gives exactly one result item on
// out_*: out_tdata is the granted index, out_tuser the status.
// The free list is a link memory with a synchronous read plus a head register.
// On a free within range, the link is written and the head moves in the cycle
// the item is accepted, and the result appears in the output register next cycle.
// An allocate from a non-empty list waits in S_ALLOC for the head's link read.
// A clear sweeps min(blocks_in_use, MAX_BLOCKS) links, writing one link a cycle.
// Reset runs the same sweep over min(256, MAX_BLOCKS) entries without a result,
// and in_tready stays low until it is done.
// The output register decouples the sides: a new item is taken while a result
// is being taken in the same cycle; while the receiver stalls with a result
// pending, in_tready is low. cfg_wr_en writes blocks_in_use; it
// governs the range check of free and the next clear.
module fixed_block_free_list_allocator
  import fbfla_pkg::*;
#(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [IDX_W-1:0]    in_tdata,   // [7:0] block_index
  input  logic [ACTION_W-1:0] in_tuser,   // [1:0] action
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [IDX_W-1:0]    out_tdata,  // [7:0] granted_index
  output logic [STATUS_W-1:0] out_tuser   // [1:0] status
);

  localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int LW = AW + 1;
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam logic [LW-1:0] LINK_NULL = LW'(MAX_BLOCKS);
  localparam int INIT_N = (RESET_BLOCKS < MAX_BLOCKS) ? RESET_BLOCKS : MAX_BLOCKS;

  logic [LW-1:0] link_mem [MAX_BLOCKS];

  state_t            state_r, state_nxt;
  logic [LW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [LW-1:0]     n_r, n_nxt;
  logic              emit_r, emit_nxt;
  logic [CFG_W-1:0]  blocks_r;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_data_r, out_data_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [LW-1:0]     link_rd_r;

  logic              in_acc;
  logic              out_load;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [LW-1:0]     mem_wdata;
  logic              mem_re;
  logic [LW-1:0]     eff_n;
  logic [LW-1:0]     cnt_inc;
  logic              cnt_last;
  logic              head_null;
  action_t           action;

  assign in_tready  = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign action     = action_t'(in_tuser);
  assign head_null  = (head_r == LINK_NULL);
  assign eff_n      = (CW'(blocks_r) > CW'(MAX_BLOCKS)) ? LINK_NULL : LW'(blocks_r);
  assign cnt_inc    = LW'(cnt_r) + LW'(1);
  assign cnt_last   = (cnt_inc == n_r);
  assign mem_re     = in_acc && (action == ACT_ALLOC) && !head_null;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    emit_nxt       = emit_r;
    out_load       = 1'b0;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r;
    mem_wdata      = cnt_last ? LINK_NULL : cnt_inc;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          out_data_nxt   = '0;
          out_status_nxt = ST_OK;
          unique case (action)
            ACT_ALLOC: begin
              if (head_null) begin
                out_load       = 1'b1;
                out_status_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_ALLOC;
              end
            end
            ACT_FREE: begin
              out_load = 1'b1;
              if (CW'(in_tdata) >= CW'(eff_n)) begin
                out_status_nxt = ST_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_tdata);
                mem_wdata = head_r;
                head_nxt  = LW'(in_tdata);
              end
            end
            ACT_CLEAR: begin
              if (eff_n == '0) begin
                head_nxt = LINK_NULL;
                out_load = 1'b1;
              end else begin
                n_nxt     = eff_n;
                cnt_nxt   = '0;
                emit_nxt  = 1'b1;
                state_nxt = S_CLEAR;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_ALLOC: begin
        // Link of the popped block arrives from memory this cycle.
        out_load       = 1'b1;
        out_data_nxt   = IDX_W'(head_r);
        out_status_nxt = ST_OK;
        head_nxt       = link_rd_r;
        state_nxt      = S_IDLE;
      end
      S_CLEAR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_last) begin
          head_nxt       = '0;
          state_nxt      = S_IDLE;
          out_load       = emit_r;
          out_data_nxt   = '0;
          out_status_nxt = ST_OK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      link_rd_r <= link_mem[AW'(head_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      head_r      <= LINK_NULL;
      cnt_r       <= '0;
      n_r         <= LW'(INIT_N);
      emit_r      <= 1'b0;
      blocks_r    <= CFG_W'(RESET_BLOCKS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        blocks_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= LINK_NULL)
    else $error("free-list head beyond null");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (LW'(cnt_r) < n_r))
    else $error("clear sweep ran past the block count");

  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ALLOC) |=> (out_valid_r && (state_r == S_IDLE)))
    else $error("allocate did not deliver its result");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready)
    else $error("input taken while a read or sweep is in flight");
`endif

endmodule

@@ test/free_list_checker.sv @@
module free_list_checker
  import fbfla_pkg::*;
#(
  parameter int POOL = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [IDX_W-1:0]    in_tdata,   // [7:0] block_index
  input  logic [ACTION_W-1:0] in_tuser,   // [1:0] action
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [IDX_W-1:0]    out_tdata,  // [7:0] granted_index
  input  logic [STATUS_W-1:0] out_tuser,  // [1:0] status
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINK_W = $clog2(POOL + 1);
  // A link equal to the pool size marks the end of the free list.
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL);

  typedef struct packed {
    logic [IDX_W-1:0] granted;
    status_t          status;
  } grant_t;

  logic [LINK_W-1:0] link_mem [POOL];
  logic [LINK_W-1:0] head;
  logic [CFG_W-1:0]  pool_count;
  grant_t            grant_q[$];

  function automatic int live_blocks();
    return (pool_count > POOL) ? POOL : int'(pool_count);
  endfunction

  function automatic void rechain();
    int n;
    n = live_blocks();
    if (n == 0) begin
      head = LINK_NULL;
    end else begin
      for (int i = 0; i < n - 1; i++) link_mem[i] = LINK_W'(i + 1);
      link_mem[n-1] = LINK_NULL;
      head = '0;
    end
  endfunction

  function automatic grant_t pool_step(action_t act, logic [IDX_W-1:0] idx);
    grant_t r;
    r.granted = '0;
    r.status = ST_OK;
    case (act)
      ACT_ALLOC: begin
        if (head >= LINK_NULL) begin
          r.status = ST_EMPTY;
        end else begin
          r.granted = head[IDX_W-1:0];
          head = link_mem[head];
        end
      end
      ACT_FREE: begin
        if (int'(idx) >= live_blocks()) begin
          r.status = ST_RANGE;
        end else begin
          link_mem[idx] = head;
          head = LINK_W'(idx);
        end
      end
      ACT_CLEAR: rechain();
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (!rst_n) begin
      foreach (link_mem[i]) link_mem[i] = LINK_NULL;
      pool_count = CFG_W'(RESET_BLOCKS);
      rechain();
      grant_q.delete();
    end else begin
      if (cfg_wr_en) pool_count = cfg_wr_data;
      // A result leaving in this cycle always belongs to an earlier item.
      if (out_tvalid && out_tready) begin
        if (grant_q.size() == 0) begin
          $display("%0t: unexpected result item, granted_index %0d status %0d",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (out_tdata !== want.granted) begin
            $display("%0t: granted_index expected %0d got %0d",
                     $time, want.granted, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, out_tuser);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) grant_q.push_back(pool_step(action_t'(in_tuser), in_tdata));
    end
    pending = grant_q.size();
  end

endmodule

@@ test/tb_fixed_block_free_list_allocator.sv @@
module tb_fixed_block_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import fbfla_pkg::*;

  localparam int POOL_SIZE    = 256;
  localparam int RANDOM_ITEMS = 1800;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam action_t ACT_UNUSED = action_t'(2'd3);

  logic                clk;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [CFG_W-1:0]    cfg_wr_data;
  logic                in_tvalid;
  logic                in_tready;
  logic [IDX_W-1:0]    in_tdata;   // [7:0] block_index
  logic [ACTION_W-1:0] in_tuser;   // [1:0] action
  logic                out_tvalid;
  logic                out_tready;
  logic [IDX_W-1:0]    out_tdata;  // [7:0] granted_index
  logic [STATUS_W-1:0] out_tuser;  // [1:0] status

  int fail_count;
  int pending;
  int items_sent = 0;
  int live = POOL_SIZE;
  int quiet = 0;
  bit in_gaps = 1'b1;
  bit out_steady = 1'b0;

  action_t          sent_q[$];
  logic [IDX_W-1:0] held_q[$];

  fixed_block_free_list_allocator #(
    .MAX_BLOCKS(POOL_SIZE)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  free_list_checker #(
    .POOL(POOL_SIZE)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Keeps the indexes currently handed out, so that most frees return a block
  // that was really allocated.
  always @(posedge clk) begin
    action_t act;
    if (rst_n) begin
      if (out_tvalid && out_tready && sent_q.size() != 0) begin
        act = sent_q.pop_front();
        if (act == ACT_ALLOC && status_t'(out_tuser) == ST_OK) begin
          held_q.push_back(out_tdata);
        end else if (act == ACT_CLEAR) begin
          held_q.delete();
        end
      end
      if (in_tvalid && in_tready) sent_q.push_back(action_t'(in_tuser));
    end
  end

  initial begin
    int stall;
    out_tready = 1'b0;
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 8);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  task automatic send_item(action_t act, logic [IDX_W-1:0] idx);
    int gap;
    gap = in_gaps ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= idx;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // The count is only changed once every result is back and the block is ready.
  task automatic set_count(logic [CFG_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0 || !in_tready) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    live = (value > POOL_SIZE) ? POOL_SIZE : int'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [IDX_W-1:0] pick_free_index();
    int k;
    logic [IDX_W-1:0] idx;
    if (held_q.size() != 0 && $urandom_range(0, 4) != 0) begin
      k = $urandom_range(0, held_q.size() - 1);
      idx = held_q[k];
      held_q.delete(k);
    end else if (live == 0 || $urandom_range(0, 2) == 0) begin
      idx = IDX_W'($urandom_range(0, 255));
    end else begin
      idx = IDX_W'($urandom_range(0, live - 1));
    end
    return idx;
  endfunction

  initial begin
    int random_start;
    int phase_len;
    int pick;
    logic [CFG_W-1:0] count;

    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_ALLOC;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Full pool after reset, then the boundary cases of each action.
    send_item(ACT_ALLOC, 8'hFF);
    send_item(ACT_ALLOC, 8'h00);
    send_item(ACT_FREE, 8'hFF);
    send_item(ACT_FREE, 8'h00);
    send_item(ACT_ALLOC, 8'h55);
    send_item(ACT_UNUSED, 8'hFF);
    send_item(ACT_CLEAR, 8'hAA);
    // A smaller count without a clear keeps the old chain but narrows frees.
    set_count(9'd1);
    send_item(ACT_ALLOC, 8'h00);
    send_item(ACT_FREE, 8'h01);
    send_item(ACT_CLEAR, 8'h00);
    send_item(ACT_ALLOC, 8'h00);
    send_item(ACT_ALLOC, 8'h00);
    send_item(ACT_FREE, 8'h00);
    // With no blocks at all the list is empty and every free is rejected.
    set_count(9'd0);
    send_item(ACT_CLEAR, 8'h00);
    send_item(ACT_ALLOC, 8'h00);
    send_item(ACT_FREE, 8'h00);
    // A count above the pool size acts as the pool size.
    set_count(9'h1FF);
    send_item(ACT_CLEAR, 8'h00);
    send_item(ACT_FREE, 8'hFF);
    send_item(ACT_ALLOC, 8'h00);

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) count = CFG_W'($urandom_range(1, 16));
      else if (pick == 6) count = '0;
      else if (pick == 7) count = CFG_W'(POOL_SIZE);
      else if (pick == 8) count = CFG_W'($urandom_range(257, 511));
      else count = CFG_W'($urandom_range(17, 255));
      set_count(count);
      in_gaps = $urandom_range(0, 3) != 0;
      out_steady = $urandom_range(0, 3) == 0;
      if ($urandom_range(0, 6) != 0) send_item(ACT_CLEAR, IDX_W'($urandom_range(0, 255)));
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) send_item(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
        else if (pick < 88) send_item(ACT_FREE, pick_free_index());
        else if (pick < 93) send_item(ACT_FREE, IDX_W'($urandom_range(0, 255)));
        else if (pick < 97) send_item(ACT_CLEAR, IDX_W'($urandom_range(0, 255)));
        else send_item(ACT_UNUSED, IDX_W'($urandom_range(0, 255)));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
